/* rtl/dtfs_pkg.sv */
// shared constants, opcode and status codes of the dirty-tracked field store
`timescale 1ns / 1ps

package dtfs_pkg;

    localparam int NUM_FIELDS = 64;
    localparam int IDX_W      = 6;
    localparam int WORD_W     = 32;
    localparam int PAIR_W     = 2 * WORD_W;
    localparam int BANK_AW    = IDX_W - 1;
    localparam int BANK_DEPTH = 2 ** BANK_AW;

    typedef enum logic [3:0] {
        OP_SET          = 4'd0,
        OP_FORCE        = 4'd1,
        OP_SET_PAIR     = 4'd2,
        OP_ADD_PAIR     = 4'd3,
        OP_RM_PAIR      = 4'd4,
        OP_BYTE         = 4'd5,
        OP_HALF         = 4'd6,
        OP_CLAMP_SET    = 4'd7,
        OP_MOD_SAT      = 4'd8,
        OP_MOD_WRAP     = 4'd9,
        OP_SET_FLAG     = 4'd10,
        OP_CLR_FLAG     = 4'd11,
        OP_SET_BYTEFLAG = 4'd12,
        OP_CLR_BYTEFLAG = 4'd13,
        OP_READ         = 4'd14
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_BAD_LANE  = 2'd2
    } status_t;

endpackage

/* rtl/dtfs_ram.sv */
// generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps

module dtfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/dirty_tracked_field_store.sv */
// Dirty-tracked field store: 64 words of 32 bits, a dirty bit per word and a sticky
// updated flag. An operation is taken on any cycle with start high (busy stays low),
// one per clock, and its result appears on the result ports with done high for one
// cycle, registered from the request stage; results cannot be held off. The words sit
// in two banks of synchronous memory (even and odd words) so a pair access reads and
// writes both halves at once; each request reads the banks as it is accepted and writes
// back from the request stage, with the previous request's write forwarded. A word whose
// dirty bit is clear reads as zero, so no clearing pass is needed after reset. The
// in_world register is written on the cfg channel, which is always ready.
`timescale 1ns / 1ps

module dirty_tracked_field_store
    import dtfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [3:0]        opcode,
    input  logic [IDX_W-1:0]  field_index,
    input  logic [PAIR_W-1:0] operand,
    input  logic [2:0]        lane,
    input  logic              add_not_subtract,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    output logic              done,
    output logic [WORD_W-1:0] read_word,
    output logic              took_effect,
    output logic [1:0]        status,
    output logic              updated_flag,
    output logic              field_dirty
);

    logic                  accept;
    logic                  s1_valid_reg;
    op_t                   s1_op_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic [PAIR_W-1:0]     s1_opnd_reg;
    logic [2:0]            s1_lane_reg;
    logic                  s1_add_reg;
    logic [BANK_AW-1:0]    even_raddr_reg;
    logic [BANK_AW-1:0]    odd_raddr_reg;

    logic [BANK_AW-1:0]    even_raddr;
    logic [BANK_AW-1:0]    odd_raddr;
    logic [WORD_W-1:0]     even_q;
    logic [WORD_W-1:0]     odd_q;
    logic [WORD_W-1:0]     even_word;
    logic [WORD_W-1:0]     odd_word;

    logic                  fwd_even_en_reg;
    logic [BANK_AW-1:0]    fwd_even_addr_reg;
    logic [WORD_W-1:0]     fwd_even_data_reg;
    logic                  fwd_odd_en_reg;
    logic [BANK_AW-1:0]    fwd_odd_addr_reg;
    logic [WORD_W-1:0]     fwd_odd_data_reg;

    logic [NUM_FIELDS-1:0] dirty_reg;
    logic [NUM_FIELDS-1:0] dirty_next;
    logic                  updated_reg;
    logic                  updated_next;
    logic                  in_world_reg;

    logic [IDX_W-1:0]      hi_idx;
    logic [WORD_W-1:0]     cur;
    logic [WORD_W-1:0]     cur_hi;
    logic [PAIR_W-1:0]     stored;
    logic [WORD_W-1:0]     v32;
    logic [WORD_W-1:0]     delta;
    logic [WORD_W-1:0]     sum;
    logic [7:0]            m8;
    logic [4:0]            bsh;
    logic [4:0]            hsh;
    logic [WORD_W-1:0]     byte_mask;
    logic [7:0]            lane_val;
    logic                  is_pair;
    logic                  bad_index;
    logic                  bad_lane;
    logic [WORD_W-1:0]     new_lo;
    logic [WORD_W-1:0]     new_hi;
    logic                  wr_lo;
    logic                  wr_hi;
    logic                  raise;
    logic                  cmp_wr;
    status_t               st;

    logic                  even_we;
    logic [WORD_W-1:0]     even_wdata;
    logic                  odd_we;
    logic [WORD_W-1:0]     odd_wdata;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // word w lives in bank w[0] at row w >> 1
    assign odd_raddr  = field_index[IDX_W-1:1];
    assign even_raddr = BANK_AW'((field_index + IDX_W'(1)) >> 1);

    dtfs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK_DEPTH)
    ) u_even_ram (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_raddr_reg),
        .wdata (even_wdata),
        .raddr (even_raddr),
        .rdata (even_q)
    );

    dtfs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK_DEPTH)
    ) u_odd_ram (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_raddr_reg),
        .wdata (odd_wdata),
        .raddr (odd_raddr),
        .rdata (odd_q)
    );

    // previous request's write-back lands on the same edge as this read
    assign even_word = (fwd_even_en_reg && fwd_even_addr_reg == even_raddr_reg)
                       ? fwd_even_data_reg : even_q;
    assign odd_word  = (fwd_odd_en_reg && fwd_odd_addr_reg == odd_raddr_reg)
                       ? fwd_odd_data_reg : odd_q;

    always_comb
    begin
        hi_idx    = s1_idx_reg + IDX_W'(1);
        cur       = dirty_reg[s1_idx_reg] ? (s1_idx_reg[0] ? odd_word : even_word)
                                          : '0;
        cur_hi    = dirty_reg[hi_idx] ? (s1_idx_reg[0] ? even_word : odd_word) : '0;
        stored    = {cur_hi, cur};
        v32       = s1_opnd_reg[WORD_W-1:0];
        delta     = s1_add_reg ? v32 : (WORD_W'(0) - v32);
        sum       = cur + delta;
        m8        = s1_opnd_reg[7:0];
        bsh       = {s1_lane_reg[1:0], 3'b000};
        hsh       = {s1_lane_reg[0], 4'b0000};
        byte_mask = WORD_W'(m8) << bsh;
        lane_val  = 8'(cur >> bsh);

        is_pair   = (s1_op_reg == OP_SET_PAIR) || (s1_op_reg == OP_ADD_PAIR)
                    || (s1_op_reg == OP_RM_PAIR);
        bad_index = ({1'b0, s1_idx_reg} >= (IDX_W + 1)'(NUM_FIELDS))
                    || (is_pair && ({1'b0, s1_idx_reg} + (IDX_W + 1)'(1)
                                    >= (IDX_W + 1)'(NUM_FIELDS)));
        bad_lane  = ((s1_op_reg inside {OP_BYTE, OP_SET_BYTEFLAG, OP_CLR_BYTEFLAG})
                     && s1_lane_reg[2])
                    || (s1_op_reg == OP_HALF && s1_lane_reg[2:1] != 2'b00);

        new_lo = cur;
        new_hi = cur_hi;
        wr_lo  = 1'b0;
        wr_hi  = 1'b0;
        raise  = 1'b1;
        cmp_wr = 1'b1;

        unique case (s1_op_reg)
            OP_SET:
            begin
                new_lo = v32;
            end
            OP_FORCE:
            begin
                new_lo = v32;
                cmp_wr = 1'b0;
                wr_lo  = 1'b1;
                raise  = 1'b0;
            end
            OP_SET_PAIR:
            begin
                cmp_wr = 1'b0;
                {new_hi, new_lo} = s1_opnd_reg;
                wr_lo  = stored != s1_opnd_reg;
                wr_hi  = wr_lo;
            end
            OP_ADD_PAIR:
            begin
                cmp_wr = 1'b0;
                {new_hi, new_lo} = s1_opnd_reg;
                wr_lo  = (s1_opnd_reg != '0) && (stored == '0);
                wr_hi  = wr_lo;
            end
            OP_RM_PAIR:
            begin
                cmp_wr = 1'b0;
                new_lo = '0;
                new_hi = '0;
                wr_lo  = (s1_opnd_reg != '0) && (stored == s1_opnd_reg);
                wr_hi  = wr_lo;
            end
            OP_BYTE:
            begin
                new_lo = (cur & ~(WORD_W'(8'hFF) << bsh)) | byte_mask;
            end
            OP_HALF:
            begin
                new_lo = (cur & ~(WORD_W'(16'hFFFF) << hsh))
                         | (WORD_W'(s1_opnd_reg[15:0]) << hsh);
            end
            OP_CLAMP_SET:
            begin
                new_lo = v32[WORD_W-1] ? '0 : v32;
            end
            OP_MOD_SAT:
            begin
                new_lo = sum[WORD_W-1] ? '0 : sum;
            end
            OP_MOD_WRAP:
            begin
                new_lo = sum;
            end
            OP_SET_FLAG:
            begin
                new_lo = cur | v32;
            end
            OP_CLR_FLAG:
            begin
                new_lo = cur & ~v32;
            end
            OP_SET_BYTEFLAG:
            begin
                cmp_wr = 1'b0;
                new_lo = cur | byte_mask;
                wr_lo  = (lane_val & m8) == 8'h00;
            end
            OP_CLR_BYTEFLAG:
            begin
                cmp_wr = 1'b0;
                new_lo = cur & ~byte_mask;
                wr_lo  = (lane_val & m8) != 8'h00;
            end
            default:
            begin
                cmp_wr = 1'b0;
            end
        endcase

        if (cmp_wr)
        begin
            wr_lo = new_lo != cur;
        end

        if (!s1_valid_reg || bad_index || bad_lane)
        begin
            wr_lo = 1'b0;
            wr_hi = 1'b0;
        end

        if (bad_index)
        begin
            st = ST_BAD_INDEX;
        end
        else if (bad_lane)
        begin
            st = ST_BAD_LANE;
        end
        else
        begin
            st = ST_OK;
        end

        dirty_next = dirty_reg;
        if (wr_lo)
        begin
            dirty_next[s1_idx_reg] = 1'b1;
        end
        if (wr_hi)
        begin
            dirty_next[hi_idx] = 1'b1;
        end

        updated_next = updated_reg | (wr_lo & raise & in_world_reg);

        even_we    = s1_idx_reg[0] ? wr_hi : wr_lo;
        even_wdata = s1_idx_reg[0] ? new_hi : new_lo;
        odd_we     = s1_idx_reg[0] ? wr_lo : wr_hi;
        odd_wdata  = s1_idx_reg[0] ? new_lo : new_hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            done            <= 1'b0;
            dirty_reg       <= '0;
            updated_reg     <= 1'b0;
            in_world_reg    <= 1'b0;
            fwd_even_en_reg <= 1'b0;
            fwd_odd_en_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= accept;
            done            <= s1_valid_reg;
            dirty_reg       <= dirty_next;
            updated_reg     <= updated_next;
            fwd_even_en_reg <= even_we;
            fwd_odd_en_reg  <= odd_we;
            if (cfg_valid && cfg_ready)
            begin
                in_world_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg      <= op_t'(opcode);
            s1_idx_reg     <= field_index;
            s1_opnd_reg    <= operand;
            s1_lane_reg    <= lane;
            s1_add_reg     <= add_not_subtract;
            even_raddr_reg <= even_raddr;
            odd_raddr_reg  <= odd_raddr;
        end
        fwd_even_addr_reg <= even_raddr_reg;
        fwd_even_data_reg <= even_wdata;
        fwd_odd_addr_reg  <= odd_raddr_reg;
        fwd_odd_data_reg  <= odd_wdata;

        if (s1_valid_reg)
        begin
            read_word    <= bad_index ? '0 : (wr_lo ? new_lo : cur);
            took_effect  <= wr_lo;
            status       <= st;
            updated_flag <= updated_next;
            field_dirty  <= bad_index ? 1'b0 : (dirty_reg[s1_idx_reg] | wr_lo);
        end
    end

`ifndef SYNTHESIS
    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> done)
        else $error("result strobe missing after request");

    a_updated_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        updated_reg |=> updated_reg)
        else $error("updated flag dropped");

    a_reject_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> !took_effect)
        else $error("rejected request reported an effect");

    a_effect_marks_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        done && took_effect |-> field_dirty)
        else $error("write did not mark the field dirty");

    a_bad_index_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_BAD_INDEX |-> read_word == '0 && !field_dirty)
        else $error("bad index result not cleared");

    a_no_raise_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_world_reg && !updated_reg |=> !updated_reg)
        else $error("updated flag raised while not in world");
`endif

endmodule

/* sim/tb_dirty_tracked_field_store.sv */
// self-checking testbench for the dirty-tracked field store
`timescale 1ns / 1ps

module tb_dirty_tracked_field_store;
    import dtfs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 6;
    localparam int RANDOM_ITEMS = 500;
    localparam int PHASES       = 4;

    typedef struct {
        logic [WORD_W-1:0] word;
        bit                took_effect;
        status_t           status;
        bit                updated;
        bit                dirty;
    } outcome_t;

    class field_store_checker;
        logic [WORD_W-1:0] words [NUM_FIELDS];
        bit                dirty [NUM_FIELDS];
        bit                updated;
        bit                in_world;
        outcome_t          predicted_outcomes [$];
        int                requests;
        int                results;
        int                failures;

        function new();
            foreach (words[i])
            begin
                words[i] = '0;
                dirty[i] = 1'b0;
            end
            updated  = 1'b0;
            in_world = 1'b0;
            requests = 0;
            results  = 0;
            failures = 0;
        endfunction

        function int pending();
            return predicted_outcomes.size();
        endfunction

        function void mark_dirty(int i, bit raise);
            dirty[i] = 1'b1;
            if (raise && in_world)
                updated = 1'b1;
        endfunction

        function bit store_if_changed(int i, logic [WORD_W-1:0] v);
            if (words[i] == v)
                return 1'b0;
            words[i] = v;
            mark_dirty(i, 1'b1);
            return 1'b1;
        endfunction

        function void write_pair(int i, logic [PAIR_W-1:0] v);
            words[i]     = v[WORD_W-1:0];
            words[i + 1] = v[PAIR_W-1:WORD_W];
            mark_dirty(i, 1'b1);
            mark_dirty(i + 1, 1'b1);
        endfunction

        function void note_request(logic [3:0] op, logic [IDX_W-1:0] idx,
                                   logic [PAIR_W-1:0] opnd, logic [2:0] lane, bit add_n);
            outcome_t          o;
            logic [WORD_W-1:0] v32, cur, d, m8, lane_bits, nv;
            logic [PAIR_W-1:0] stored;
            int                i, bsh, hsh;
            bit                pair, wrote, byte_op;
            i       = int'(idx);
            v32     = opnd[WORD_W-1:0];
            pair    = (op == OP_SET_PAIR) || (op == OP_ADD_PAIR) || (op == OP_RM_PAIR);
            byte_op = (op == OP_BYTE) || (op == OP_SET_BYTEFLAG) || (op == OP_CLR_BYTEFLAG);
            wrote   = 1'b0;
            requests++;
            if (i >= NUM_FIELDS || (pair && i + 1 >= NUM_FIELDS))
            begin
                o.word        = '0;
                o.took_effect = 1'b0;
                o.status      = ST_BAD_INDEX;
                o.updated     = updated;
                o.dirty       = 1'b0;
                predicted_outcomes.push_back(o);
                return;
            end
            o.status = ST_OK;
            if ((byte_op && lane > 3) || (op == OP_HALF && lane > 1))
                o.status = ST_BAD_LANE;
            else
            begin
                cur       = words[i];
                stored    = pair ? {words[i + 1], cur} : '0;
                bsh       = lane[1:0] * 8;
                hsh       = lane[0] * 16;
                d         = add_n ? v32 : (32'd0 - v32);
                m8        = {24'h0, opnd[7:0]};
                lane_bits = (cur >> bsh) & 32'hFF;
                case (op)
                    OP_SET:
                        wrote = store_if_changed(i, v32);
                    OP_FORCE:
                    begin
                        words[i] = v32;
                        mark_dirty(i, 1'b0);
                        wrote = 1'b1;
                    end
                    OP_SET_PAIR:
                        if (stored != opnd)
                        begin
                            write_pair(i, opnd);
                            wrote = 1'b1;
                        end
                    OP_ADD_PAIR:
                        if (opnd != '0 && stored == '0)
                        begin
                            write_pair(i, opnd);
                            wrote = 1'b1;
                        end
                    OP_RM_PAIR:
                        if (opnd != '0 && stored == opnd)
                        begin
                            write_pair(i, '0);
                            wrote = 1'b1;
                        end
                    OP_BYTE:
                        wrote = store_if_changed(i, (cur & ~(32'hFF << bsh)) | (m8 << bsh));
                    OP_HALF:
                        wrote = store_if_changed(i, (cur & ~(32'hFFFF << hsh)) |
                                                    ({16'h0, opnd[15:0]} << hsh));
                    OP_CLAMP_SET:
                        wrote = store_if_changed(i, v32[31] ? 32'd0 : v32);
                    OP_MOD_SAT:
                    begin
                        nv = cur + d;
                        wrote = store_if_changed(i, nv[31] ? 32'd0 : nv);
                    end
                    OP_MOD_WRAP:
                        wrote = store_if_changed(i, cur + d);
                    OP_SET_FLAG:
                        wrote = store_if_changed(i, cur | v32);
                    OP_CLR_FLAG:
                        wrote = store_if_changed(i, cur & ~v32);
                    OP_SET_BYTEFLAG:
                        if ((lane_bits & m8) == 0)
                        begin
                            words[i] = cur | (m8 << bsh);
                            mark_dirty(i, 1'b1);
                            wrote = 1'b1;
                        end
                    OP_CLR_BYTEFLAG:
                        if ((lane_bits & m8) != 0)
                        begin
                            words[i] = cur & ~(m8 << bsh);
                            mark_dirty(i, 1'b1);
                            wrote = 1'b1;
                        end
                    default:
                        ;
                endcase
            end
            o.word        = words[i];
            o.took_effect = wrote;
            o.updated     = updated;
            o.dirty       = dirty[i];
            predicted_outcomes.push_back(o);
        endfunction

        function void check_outcome(logic [WORD_W-1:0] word, logic took, logic [1:0] st,
                                    logic upd, logic dirt);
            outcome_t o;
            results++;
            if (predicted_outcomes.size() == 0)
            begin
                $error("result with no request outstanding: read_word %h", word);
                failures++;
                return;
            end
            o = predicted_outcomes.pop_front();
            if (word !== o.word)
            begin
                $error("read_word: expected %h, actual %h", o.word, word);
                failures++;
            end
            if (took !== o.took_effect)
            begin
                $error("took_effect: expected %b, actual %b", o.took_effect, took);
                failures++;
            end
            if (st !== o.status)
            begin
                $error("status: expected %0d, actual %0d", o.status, st);
                failures++;
            end
            if (upd !== o.updated)
            begin
                $error("updated_flag: expected %b, actual %b", o.updated, upd);
                failures++;
            end
            if (dirt !== o.dirty)
            begin
                $error("field_dirty: expected %b, actual %b", o.dirty, dirt);
                failures++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n            = 1'b0;
    logic              start            = 1'b0;
    logic              busy;
    logic [3:0]        opcode           = '0;
    logic [IDX_W-1:0]  field_index      = '0;
    logic [PAIR_W-1:0] operand          = '0;
    logic [2:0]        lane             = '0;
    logic              add_not_subtract = 1'b0;
    logic              cfg_valid        = 1'b0;
    logic              cfg_ready;
    logic              cfg_data         = 1'b0;
    logic              done;
    logic [WORD_W-1:0] read_word;
    logic              took_effect;
    logic [1:0]        status;
    logic              updated_flag;
    logic              field_dirty;

    field_store_checker checker_h = new();
    int                 cycles    = 0;
    int                 world_writes = 0;

    dirty_tracked_field_store uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .field_index      (field_index),
        .operand          (operand),
        .lane             (lane),
        .add_not_subtract (add_not_subtract),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .done             (done),
        .read_word        (read_word),
        .took_effect      (took_effect),
        .status           (status),
        .updated_flag     (updated_flag),
        .field_dirty      (field_dirty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, checker_h.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                checker_h.in_world = cfg_data;
            if (start && !busy)
                checker_h.note_request(opcode, field_index, operand, lane, add_not_subtract);
            if (done)
                checker_h.check_outcome(read_word, took_effect, status, updated_flag,
                                        field_dirty);
        end
    end

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_request(input logic [3:0] op, input logic [IDX_W-1:0] idx,
                                input logic [PAIR_W-1:0] opnd, input logic [2:0] ln,
                                input bit add_n);
        opcode           <= op;
        field_index      <= idx;
        operand          <= opnd;
        lane             <= ln;
        add_not_subtract <= add_n;
        start            <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_block();
        start <= 1'b0;
        do
            @(posedge clk);
        while (checker_h.pending() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_in_world(input bit v);
        drain_block();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        world_writes++;
    endtask

    task automatic random_request();
        logic [3:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [PAIR_W-1:0] opnd;
        logic [2:0]        ln;
        int                r;
        op = 4'($urandom_range(0, 15));
        r  = $urandom_range(0, 99);
        if (r < 60)
            idx = IDX_W'($urandom_range(0, 7));
        else if (r < 75)
            idx = IDX_W'($urandom_range(NUM_FIELDS - 4, NUM_FIELDS - 1));
        else
            idx = IDX_W'($urandom_range(0, NUM_FIELDS - 1));
        case ($urandom_range(0, 9))
            0: opnd = '0;
            1: opnd = '1;
            2: opnd = (idx < NUM_FIELDS - 1) ?
                      {checker_h.words[idx + 1], checker_h.words[idx]} :
                      {32'h0, checker_h.words[idx]};
            3: opnd = {32'h0, checker_h.words[idx]};
            4: opnd = 64'($urandom_range(0, 255));
            5: opnd = {$urandom, 1'b0, 31'h7FFFFFF0} + 64'($urandom_range(0, 31));
            default: opnd = {$urandom, $urandom};
        endcase
        ln = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(0, 3))
                                          : 3'($urandom_range(0, 7));
        send_request(op, idx, opnd, ln, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int idle_pct;
        int gap;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with the block not live
        send_request(OP_READ,         0,  64'h0,                  0, 1'b0);
        send_request(OP_SET,          0,  64'hFFFF_FFFF,          0, 1'b0);
        send_request(OP_SET,          0,  64'hFFFF_FFFF,          0, 1'b0);
        send_request(OP_FORCE,        1,  64'h0,                  0, 1'b0);
        send_request(OP_SET_PAIR,     62, '1,                     0, 1'b0);
        send_request(OP_SET_PAIR,     63, 64'h1234,               0, 1'b0);
        send_request(OP_ADD_PAIR,     4,  64'h0,                  0, 1'b0);
        send_request(OP_ADD_PAIR,     4,  64'h8000_0001_0000_0002, 0, 1'b0);
        send_request(OP_ADD_PAIR,     4,  64'h1,                  0, 1'b0);
        send_request(OP_RM_PAIR,      4,  64'h1,                  0, 1'b0);
        send_request(OP_RM_PAIR,      4,  64'h8000_0001_0000_0002, 0, 1'b0);
        send_request(OP_BYTE,         8,  64'hFF,                 3, 1'b0);
        send_request(OP_BYTE,         8,  64'h55,                 4, 1'b0);
        send_request(OP_HALF,         8,  64'hFFFF_FFFF_FFFF_1234, 1, 1'b0);
        send_request(OP_HALF,         8,  64'h1,                  2, 1'b0);
        send_request(OP_CLAMP_SET,    9,  64'h7FFF_FFFF,          0, 1'b0);
        send_request(OP_CLAMP_SET,    9,  64'hFFFF_FFFF,          0, 1'b0);
        send_request(OP_MOD_SAT,      10, 64'h5,                  0, 1'b0);
        send_request(OP_MOD_SAT,      10, 64'h7FFF_FFFF,          0, 1'b1);
        send_request(OP_MOD_SAT,      10, 64'h1,                  0, 1'b1);
        send_request(OP_MOD_WRAP,     11, 64'h1,                  0, 1'b0);
        send_request(OP_MOD_WRAP,     11, 64'h1,                  0, 1'b1);
        send_request(OP_SET_FLAG,     12, 64'h00F0_000F,          0, 1'b0);
        send_request(OP_CLR_FLAG,     12, 64'h0000_0003,          0, 1'b0);
        send_request(OP_SET_BYTEFLAG, 12, 64'h01,                 0, 1'b0);
        send_request(OP_SET_BYTEFLAG, 12, 64'h01,                 0, 1'b0);
        send_request(OP_SET_BYTEFLAG, 13, 64'h00,                 2, 1'b0);
        send_request(OP_CLR_BYTEFLAG, 12, 64'h0F,                 0, 1'b0);
        send_request(OP_CLR_BYTEFLAG, 12, 64'h0F,                 7, 1'b0);
        send_request(4'hF,            0,  64'h0,                  0, 1'b0);

        // live object: force must not raise the updated flag, a plain set must
        write_in_world(1'b1);
        send_request(OP_FORCE,        20, 64'hA5A5_A5A5,          0, 1'b0);
        send_request(OP_SET,          20, 64'hA5A5_A5A5,          0, 1'b0);
        send_request(OP_SET,          20, 64'h5A5A_5A5A,          0, 1'b0);
        send_request(OP_READ,         20, 64'h0,                  0, 1'b0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_in_world(phase[0]);
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 78;
                2: idle_pct = 16;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                if (phase == 3 && n % 20 == 0)
                    idle_pct = (idle_pct == 0) ? 50 : 0;
                random_request();
                if (phase == 1 && n % 32 == 31)
                    drain_block();
                else
                begin
                    gap = 0;
                    while (gap < 30 && $urandom_range(0, 99) < idle_pct)
                        gap++;
                    if (gap > 0)
                    begin
                        start <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
        end

        drain_block();
        repeat (SETTLE) @(posedge clk);
        $display("%0d requests over %0d idle patterns, %0d results checked",
                 checker_h.requests, PHASES, checker_h.results);
        $display("in_world written %0d times, %0d mismatches, %0d results outstanding",
                 world_writes, checker_h.failures, checker_h.pending());
        if (checker_h.failures == 0 && checker_h.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
